@@ src/jst_pkg.sv @@
// Shared types and constants for the job slot table.
`timescale 1ns / 1ps

package jst_pkg;

    localparam int SLOTS_DEF    = 16;
    localparam int KEY_BITS_DEF = 22;
    localparam int NUM_BITS     = 5;
    localparam int ST_BITS      = 2;
    localparam int OP_BITS      = 3;
    localparam int STATUS_BITS  = 2;

    localparam logic [ST_BITS-1:0] RUN_FG = 2'd1;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_SET_KEY  = 3'd2,
        OP_SET_NUM  = 3'd3,
        OP_FIND_FG  = 3'd4,
        OP_FIND_KEY = 3'd5,
        OP_FIND_NUM = 3'd6,
        OP_CLEAR    = 3'd7
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        STS_OK       = 2'd0,
        STS_INVALID  = 2'd1,
        STS_NOTFOUND = 2'd2,
        STS_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } t_fsm;

endpackage

@@ src/jst_cell.sv @@
// One slot cell of the rotating slot ring.
`timescale 1ns / 1ps

module jst_cell #(
    parameter int KEY_BITS = jst_pkg::KEY_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_shift,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic [jst_pkg::NUM_BITS-1:0] i_num,
    input  logic [jst_pkg::ST_BITS-1:0]  i_st,
    output logic [KEY_BITS-1:0]         o_key,
    output logic [jst_pkg::NUM_BITS-1:0] o_num,
    output logic [jst_pkg::ST_BITS-1:0]  o_st
);

    logic [KEY_BITS-1:0]          r_key;
    logic [jst_pkg::NUM_BITS-1:0] r_num;
    logic [jst_pkg::ST_BITS-1:0]  r_st;

    // take the neighbour's entry on every shift, hold otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key <= '0;
            r_num <= '0;
            r_st  <= '0;
        end else if (i_shift) begin
            r_key <= i_key;
            r_num <= i_num;
            r_st  <= i_st;
        end
    end

    assign o_key = r_key;
    assign o_num = r_num;
    assign o_st  = r_st;

endmodule

@@ src/jst_ctrl.sv @@
// Scan controller: examines the ring head, writes back the tail, holds the result.
`timescale 1ns / 1ps

module jst_ctrl #(
    parameter int SLOTS    = jst_pkg::SLOTS_DEF,
    parameter int KEY_BITS = jst_pkg::KEY_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_ready,
    input  jst_pkg::t_op                   i_cmd_op,
    input  logic [KEY_BITS-1:0]            i_cmd_key,
    input  logic [jst_pkg::NUM_BITS-1:0]   i_cmd_num,
    input  logic [jst_pkg::ST_BITS-1:0]    i_cmd_st,
    // ring head and write-back
    input  logic [KEY_BITS-1:0]            i_head_key,
    input  logic [jst_pkg::NUM_BITS-1:0]   i_head_num,
    input  logic [jst_pkg::ST_BITS-1:0]    i_head_st,
    output logic                           o_shift,
    output logic [KEY_BITS-1:0]            o_wb_key,
    output logic [jst_pkg::NUM_BITS-1:0]   o_wb_num,
    output logic [jst_pkg::ST_BITS-1:0]    o_wb_st,
    // result
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output jst_pkg::t_status               o_res_status,
    output logic [KEY_BITS-1:0]            o_res_key,
    output logic [jst_pkg::NUM_BITS-1:0]   o_res_num,
    output logic [jst_pkg::ST_BITS-1:0]    o_res_st
);

    localparam int CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW    = jst_pkg::NUM_BITS;
    localparam int SW    = jst_pkg::ST_BITS;

    jst_pkg::t_fsm    r_fsm, n_fsm;
    jst_pkg::t_op     r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [NW-1:0]    r_num;
    logic [SW-1:0]    r_nst;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_found, n_found;
    logic [NW-1:0]    r_max, n_max;
    logic [NW-1:0]    r_next, n_next;
    logic [KEY_BITS-1:0] r_cap_key, n_cap_key;
    logic [NW-1:0]    r_cap_num, n_cap_num;
    logic [SW-1:0]    r_cap_st, n_cap_st;

    logic             r_ov, n_ov;
    jst_pkg::t_status r_o_status, n_o_status;
    logic [KEY_BITS-1:0] r_o_key, n_o_key;
    logic [NW-1:0]    r_o_num, n_o_num;
    logic [SW-1:0]    r_o_st, n_o_st;

    logic             occ, key_ok, num_ok, hit, accept;
    logic [NW:0]      inc_next, inc_max;
    jst_pkg::t_status fin_status;

    assign o_cmd_ready = (r_fsm == jst_pkg::FSM_IDLE);
    assign accept      = i_cmd_valid && o_cmd_ready;

    // wrap the next number to one once it would pass the slot count
    function automatic logic [NW-1:0] wrap_next(input logic [NW:0] n);
        logic [NW-1:0] w;
        if (n > (NW+1)'(SLOTS)) begin
            w = NW'(1);
        end else begin
            w = n[NW-1:0];
        end
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= jst_pkg::FSM_IDLE;
            r_cnt   <= '0;
            r_found <= 1'b0;
            r_max   <= '0;
            r_next  <= NW'(1);
            r_ov    <= 1'b0;
        end else begin
            r_fsm   <= n_fsm;
            r_cnt   <= n_cnt;
            r_found <= n_found;
            r_max   <= n_max;
            r_next  <= n_next;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_cmd_op;
            r_key <= i_cmd_key;
            r_num <= i_cmd_num;
            r_nst <= i_cmd_st;
        end
        r_cap_key  <= n_cap_key;
        r_cap_num  <= n_cap_num;
        r_cap_st   <= n_cap_st;
        r_o_status <= n_o_status;
        r_o_key    <= n_o_key;
        r_o_num    <= n_o_num;
        r_o_st     <= n_o_st;
    end

    always_comb begin
        n_fsm      = r_fsm;
        n_cnt      = r_cnt;
        n_found    = r_found;
        n_max      = r_max;
        n_next     = r_next;
        n_cap_key  = r_cap_key;
        n_cap_num  = r_cap_num;
        n_cap_st   = r_cap_st;
        n_ov       = r_ov;
        n_o_status = r_o_status;
        n_o_key    = r_o_key;
        n_o_num    = r_o_num;
        n_o_st     = r_o_st;
        o_shift    = 1'b0;
        o_wb_key   = i_head_key;
        o_wb_num   = i_head_num;
        o_wb_st    = i_head_st;
        occ        = (i_head_key != '0);
        key_ok     = (r_key != '0);
        num_ok     = (r_num != '0);
        hit        = 1'b0;
        inc_next   = {1'b0, r_next} + (NW+1)'(1);
        inc_max    = {1'b0, r_max} + (NW+1)'(1);
        fin_status = jst_pkg::STS_OK;

        // drain the result register independently of the scan
        if (r_ov && i_res_ready) begin
            n_ov = 1'b0;
        end

        case (r_op)
            jst_pkg::OP_ADD: begin
                hit = key_ok && !occ;
            end
            jst_pkg::OP_REMOVE, jst_pkg::OP_SET_KEY, jst_pkg::OP_FIND_KEY: begin
                hit = key_ok && occ && (i_head_key == r_key);
            end
            jst_pkg::OP_SET_NUM, jst_pkg::OP_FIND_NUM: begin
                hit = num_ok && occ && (i_head_num == r_num);
            end
            jst_pkg::OP_FIND_FG: begin
                hit = occ && (i_head_st == jst_pkg::RUN_FG);
            end
            default: begin
                hit = 1'b0;
            end
        endcase
        hit = hit && !r_found;

        // final status from the scan flags
        case (r_op)
            jst_pkg::OP_ADD: begin
                if (!key_ok) begin
                    fin_status = jst_pkg::STS_INVALID;
                end else if (r_found) begin
                    fin_status = jst_pkg::STS_OK;
                end else begin
                    fin_status = jst_pkg::STS_FULL;
                end
            end
            jst_pkg::OP_REMOVE, jst_pkg::OP_SET_KEY, jst_pkg::OP_FIND_KEY: begin
                if (!key_ok) begin
                    fin_status = jst_pkg::STS_INVALID;
                end else if (r_found) begin
                    fin_status = jst_pkg::STS_OK;
                end else begin
                    fin_status = jst_pkg::STS_NOTFOUND;
                end
            end
            jst_pkg::OP_SET_NUM, jst_pkg::OP_FIND_NUM: begin
                if (!num_ok) begin
                    fin_status = jst_pkg::STS_INVALID;
                end else if (r_found) begin
                    fin_status = jst_pkg::STS_OK;
                end else begin
                    fin_status = jst_pkg::STS_NOTFOUND;
                end
            end
            jst_pkg::OP_FIND_FG: begin
                fin_status = r_found ? jst_pkg::STS_OK : jst_pkg::STS_NOTFOUND;
            end
            default: begin
                fin_status = jst_pkg::STS_OK;
            end
        endcase

        case (r_fsm)
            jst_pkg::FSM_IDLE: begin
                if (accept) begin
                    n_fsm   = jst_pkg::FSM_SCAN;
                    n_cnt   = '0;
                    n_found = 1'b0;
                    n_max   = '0;
                end
            end
            jst_pkg::FSM_SCAN: begin
                o_shift = 1'b1;
                if (hit) begin
                    case (r_op)
                        jst_pkg::OP_ADD: begin
                            o_wb_key = r_key;
                            o_wb_num = r_next;
                            o_wb_st  = r_nst;
                        end
                        jst_pkg::OP_REMOVE: begin
                            o_wb_key = '0;
                            o_wb_num = '0;
                            o_wb_st  = '0;
                        end
                        jst_pkg::OP_SET_KEY, jst_pkg::OP_SET_NUM: begin
                            o_wb_st = r_nst;
                        end
                        default: begin
                            o_wb_st = i_head_st;
                        end
                    endcase
                    n_found = 1'b1;
                    // a removal reports the slot as it was before it was freed
                    if (r_op == jst_pkg::OP_REMOVE) begin
                        n_cap_key = i_head_key;
                        n_cap_num = i_head_num;
                        n_cap_st  = i_head_st;
                    end else begin
                        n_cap_key = o_wb_key;
                        n_cap_num = o_wb_num;
                        n_cap_st  = o_wb_st;
                    end
                end
                if (r_op == jst_pkg::OP_CLEAR) begin
                    o_wb_key = '0;
                    o_wb_num = '0;
                    o_wb_st  = '0;
                end
                // largest number among the slots that stay
                if (!(hit && r_op == jst_pkg::OP_REMOVE) && (i_head_num > r_max)) begin
                    n_max = i_head_num;
                end
                if (r_cnt == CNT_W'(SLOTS - 1)) begin
                    n_fsm = jst_pkg::FSM_DONE;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            jst_pkg::FSM_DONE: begin
                if (!r_ov || i_res_ready) begin
                    n_ov       = 1'b1;
                    n_o_status = fin_status;
                    if (fin_status == jst_pkg::STS_OK && r_found) begin
                        n_o_key = r_cap_key;
                        n_o_num = r_cap_num;
                        n_o_st  = r_cap_st;
                    end else begin
                        n_o_key = '0;
                        n_o_num = '0;
                        n_o_st  = '0;
                    end
                    if (r_found && r_op == jst_pkg::OP_ADD) begin
                        n_next = wrap_next(inc_next);
                    end else if (r_found && r_op == jst_pkg::OP_REMOVE) begin
                        n_next = wrap_next(inc_max);
                    end
                    n_fsm = jst_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_fsm = jst_pkg::FSM_IDLE;
            end
        endcase
    end

    assign o_res_valid  = r_ov;
    assign o_res_status = r_o_status;
    assign o_res_key    = r_o_key;
    assign o_res_num    = r_o_num;
    assign o_res_st     = r_o_st;

endmodule

@@ src/job_slot_table_top.sv @@
// Top level of the job slot table: slot ring and scan controller.
`timescale 1ns / 1ps

// Job slot table. SLOTS slots, each a process key, a job number and a run
// state, live in a ring of cells that rotates by one slot per cycle while a
// command is worked on. Every command (add, remove by key, set state by key
// or number, find foreground, find by key or number, clear all) makes one
// full turn of the ring, so the controller sees every slot in index order,
// matches or rewrites it as it passes, and the ring is back in order at the
// end. After its transfer on the input, a command scans all SLOTS slots
// in turn, then its result moves from the done state into the output
// register. A new command is taken only once the previous one has left
// the scan and its result has been written to the output register, so
// commands do not overlap in the ring. The result register holds
// one finished result while the next command is already scanning; if it is
// still occupied when that scan ends, the block waits for the master side
// to drain it. A removal also finds the largest remaining job number during
// the same turn, so the next number is ready without a second pass. Key or
// number zero is rejected, and the next job number wraps to one once it
// would exceed SLOTS. There are no configuration registers and no clearing
// pass after reset: the ring resets to all slots free with the next number
// set to one.

module job_slot_table_top #(
    parameter int SLOTS    = jst_pkg::SLOTS_DEF,
    parameter int KEY_BITS = jst_pkg::KEY_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // fields from bit 0: proc_key, job_num, new_state, zero padding
    input  logic [((KEY_BITS + jst_pkg::NUM_BITS + jst_pkg::ST_BITS + 7) / 8) * 8 - 1:0]
                                  i_s_tdata,
    // fields from bit 0: op
    input  logic [jst_pkg::OP_BITS-1:0] i_s_tuser,
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // fields from bit 0: out_key, out_num, out_state, zero padding
    output logic [((KEY_BITS + jst_pkg::NUM_BITS + jst_pkg::ST_BITS + 7) / 8) * 8 - 1:0]
                                  o_m_tdata,
    // fields from bit 0: status
    output logic [jst_pkg::STATUS_BITS-1:0] o_m_tuser
);

    localparam int NW     = jst_pkg::NUM_BITS;
    localparam int SW     = jst_pkg::ST_BITS;
    localparam int FLD_W  = KEY_BITS + NW + SW;
    localparam int IN_W   = ((FLD_W + 7) / 8) * 8;
    localparam int PAD_W  = IN_W - FLD_W;

    logic [KEY_BITS-1:0] w_key [SLOTS];
    logic [NW-1:0]       w_num [SLOTS];
    logic [SW-1:0]       w_st  [SLOTS];

    logic                w_shift;
    logic [KEY_BITS-1:0] w_wb_key;
    logic [NW-1:0]       w_wb_num;
    logic [SW-1:0]       w_wb_st;

    jst_pkg::t_status    w_res_status;
    logic [KEY_BITS-1:0] w_res_key;
    logic [NW-1:0]       w_res_num;
    logic [SW-1:0]       w_res_st;

    // ring: each cell takes its upper neighbour, the top cell takes the write-back
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        logic [KEY_BITS-1:0] w_in_key;
        logic [NW-1:0]       w_in_num;
        logic [SW-1:0]       w_in_st;

        if (g == SLOTS - 1) begin : g_tail
            assign w_in_key = w_wb_key;
            assign w_in_num = w_wb_num;
            assign w_in_st  = w_wb_st;
        end else begin : g_mid
            assign w_in_key = w_key[g+1];
            assign w_in_num = w_num[g+1];
            assign w_in_st  = w_st[g+1];
        end

        jst_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_key   (w_in_key),
            .i_num   (w_in_num),
            .i_st    (w_in_st),
            .o_key   (w_key[g]),
            .o_num   (w_num[g]),
            .o_st    (w_st[g])
        );
    end

    jst_ctrl #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_s_tvalid),
        .o_cmd_ready  (o_s_tready),
        .i_cmd_op     (jst_pkg::t_op'(i_s_tuser)),
        .i_cmd_key    (i_s_tdata[KEY_BITS-1:0]),
        .i_cmd_num    (i_s_tdata[KEY_BITS+NW-1:KEY_BITS]),
        .i_cmd_st     (i_s_tdata[FLD_W-1:KEY_BITS+NW]),
        .i_head_key   (w_key[0]),
        .i_head_num   (w_num[0]),
        .i_head_st    (w_st[0]),
        .o_shift      (w_shift),
        .o_wb_key     (w_wb_key),
        .o_wb_num     (w_wb_num),
        .o_wb_st      (w_wb_st),
        .o_res_valid  (o_m_tvalid),
        .i_res_ready  (i_m_tready),
        .o_res_status (w_res_status),
        .o_res_key    (w_res_key),
        .o_res_num    (w_res_num),
        .o_res_st     (w_res_st)
    );

    // pack the result; padding bits stay zero
    if (PAD_W > 0) begin : g_pad
        assign o_m_tdata = {{PAD_W{1'b0}}, w_res_st, w_res_num, w_res_key};
    end else begin : g_nopad
        assign o_m_tdata = {w_res_st, w_res_num, w_res_key};
    end

    assign o_m_tuser = w_res_status;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the job slot table top level.
`timescale 1ns / 1ps

module tb_top;

    import jst_pkg::*;

    localparam int SLOTS   = SLOTS_DEF;
    localparam int KEY_W   = KEY_BITS_DEF;
    localparam int FIELD_W = KEY_W + NUM_BITS + ST_BITS;
    localparam int DATA_W  = ((FIELD_W + 7) / 8) * 8;
    localparam int RAND_ITEMS = 1650;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    typedef struct {
        t_op                 op;
        logic [KEY_W-1:0]    key;
        logic [NUM_BITS-1:0] num;
        logic [ST_BITS-1:0]  st;
    } job_cmd_t;

    typedef struct {
        t_status             status;
        logic [KEY_W-1:0]    key;
        logic [NUM_BITS-1:0] num;
        logic [ST_BITS-1:0]  st;
    } job_result_t;

    typedef struct {
        job_cmd_t    cmd;
        bit          typed;
        job_result_t res;
    } plan_row_t;

    typedef enum int {
        SEQ_FILL,
        SEQ_WORK,
        SEQ_DRAIN,
        SEQ_NOISE,
        SEQ_CLEAR
    } seq_kind_t;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [DATA_W-1:0]             i_s_tdata;
    logic [OP_BITS-1:0]            i_s_tuser;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [DATA_W-1:0]             o_m_tdata;
    logic [STATUS_BITS-1:0]        o_m_tuser;

    // Predicted contents of the table
    logic [KEY_W-1:0]    job_key [SLOTS];
    logic [NUM_BITS-1:0] job_num [SLOTS];
    logic [ST_BITS-1:0]  job_run [SLOTS];
    int                  next_job;

    job_result_t results_due[$];
    plan_row_t   opening_plan[$];

    int          fail_count;
    int          cycle_count;
    int          src_calm;
    int          snk_calm;
    job_result_t got;
    job_result_t want;

    job_slot_table_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Apply one command to the predicted table and return its result.
    function automatic job_result_t predict_job(job_cmd_t c);
        job_result_t r;
        int          hit;
        int          mx;
        r.status = STS_OK;
        r.key    = '0;
        r.num    = '0;
        r.st     = '0;
        hit      = -1;
        case (c.op)
            OP_ADD: begin
                if (c.key == 0) begin
                    r.status = STS_INVALID;
                end else begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (job_key[i] == 0) hit = i;
                    if (hit < 0) begin
                        r.status = STS_FULL;
                    end else begin
                        job_key[hit] = c.key;
                        job_run[hit] = c.st;
                        job_num[hit] = next_job[NUM_BITS-1:0];
                        next_job     = (next_job + 1 > SLOTS) ? 1 : next_job + 1;
                    end
                end
            end
            OP_REMOVE, OP_SET_KEY, OP_FIND_KEY: begin
                if (c.key == 0) begin
                    r.status = STS_INVALID;
                end else begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (job_key[i] != 0 && job_key[i] == c.key) hit = i;
                    if (hit < 0) begin
                        r.status = STS_NOTFOUND;
                    end else if (c.op == OP_SET_KEY) begin
                        job_run[hit] = c.st;
                    end else if (c.op == OP_REMOVE) begin
                        // capture the slot before it is freed
                        r.key = job_key[hit];
                        r.num = job_num[hit];
                        r.st  = job_run[hit];
                        job_key[hit] = '0;
                        job_num[hit] = '0;
                        job_run[hit] = '0;
                        mx = 0;
                        for (int i = 0; i < SLOTS; i++)
                            if (int'(job_num[i]) > mx) mx = int'(job_num[i]);
                        next_job = (mx + 1 > SLOTS) ? 1 : mx + 1;
                        hit = -1;
                    end
                end
            end
            OP_SET_NUM, OP_FIND_NUM: begin
                if (c.num == 0) begin
                    r.status = STS_INVALID;
                end else begin
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (job_key[i] != 0 && job_num[i] == c.num) hit = i;
                    if (hit < 0)
                        r.status = STS_NOTFOUND;
                    else if (c.op == OP_SET_NUM)
                        job_run[hit] = c.st;
                end
            end
            OP_FIND_FG: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (job_key[i] != 0 && job_run[i] == RUN_FG) hit = i;
                if (hit < 0) r.status = STS_NOTFOUND;
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    job_key[i] = '0;
                    job_num[i] = '0;
                    job_run[i] = '0;
                end
            end
        endcase
        if (hit >= 0) begin
            r.key = job_key[hit];
            r.num = job_num[hit];
            r.st  = job_run[hit];
        end
        return r;
    endfunction

    function automatic plan_row_t plan(t_op op, logic [KEY_W-1:0] key,
                                       logic [NUM_BITS-1:0] num, logic [ST_BITS-1:0] st,
                                       bit typed, t_status s, logic [KEY_W-1:0] rk,
                                       logic [NUM_BITS-1:0] rn, logic [ST_BITS-1:0] rs);
        plan_row_t p;
        p.cmd.op     = op;
        p.cmd.key    = key;
        p.cmd.num    = num;
        p.cmd.st     = st;
        p.typed      = typed;
        p.res.status = s;
        p.res.key    = rk;
        p.res.num    = rn;
        p.res.st     = rs;
        return p;
    endfunction

    // Random wait per item, with occasional stretches of back-to-back traffic.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // Mostly a small pool so that duplicates and repeat hits happen.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return KEY_W'($urandom_range(1, 24));
        if (r == 6) return KEY_MAX;
        return KEY_W'($urandom());
    endfunction

    function automatic job_cmd_t build_cmd(seq_kind_t kind);
        job_cmd_t c;
        int       idx;
        c.op  = OP_ADD;
        c.key = pick_key();
        c.num = NUM_BITS'($urandom_range(0, 31));
        c.st  = ST_BITS'($urandom_range(0, 3));
        idx   = $urandom_range(0, SLOTS - 1);
        case (kind)
            SEQ_FILL: c.op = OP_ADD;
            SEQ_WORK: begin
                c.op = ($urandom_range(0, 4) == 0) ? OP_ADD : t_op'($urandom_range(1, 6));
                if ($urandom_range(0, 3) != 0 && job_key[idx] != 0) begin
                    c.key = job_key[idx];
                    c.num = job_num[idx];
                end
            end
            SEQ_DRAIN: begin
                c.op = OP_REMOVE;
                if ($urandom_range(0, 4) != 0 && job_key[idx] != 0) c.key = job_key[idx];
            end
            SEQ_NOISE: begin
                c.op  = t_op'($urandom_range(0, 7));
                c.key = KEY_W'($urandom());
            end
            default: c.op = OP_CLEAR;
        endcase
        return c;
    endfunction

    // Present one command, hold it until the transfer, then queue its result.
    task automatic send_cmd(job_cmd_t c, bit typed, job_result_t typed_res);
        int          gap;
        job_result_t p;
        gap = draw_wait(src_calm);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid = 1'b1;
        i_s_tdata  = DATA_W'({c.st, c.num, c.key});
        i_s_tuser  = c.op;
        do @(posedge i_clk); while (!o_s_tready);
        p = predict_job(c);
        results_due.push_back(typed ? typed_res : p);
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
        $display("FAIL");
        $finish;
    end

    // Result side: stall for a random number of cycles before each transfer.
    initial begin : result_sink
        int gap;
        i_m_tready = 1'b0;
        snk_calm   = 0;
        @(posedge i_rst_n);
        forever begin
            gap = draw_wait(snk_calm);
            repeat (gap) begin
                @(negedge i_clk);
                i_m_tready = 1'b0;
            end
            @(negedge i_clk);
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = t_status'(o_m_tuser);
            got.key    = o_m_tdata[KEY_W-1:0];
            got.num    = o_m_tdata[KEY_W+NUM_BITS-1:KEY_W];
            got.st     = o_m_tdata[FIELD_W-1:KEY_W+NUM_BITS];
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result status %0d tdata %h", $time,
                         o_m_tuser, o_m_tdata);
                fail_count++;
            end else begin
                want = results_due.pop_front();
                if (got.status !== want.status || got.key !== want.key ||
                    got.num !== want.num || got.st !== want.st ||
                    o_m_tdata[DATA_W-1:FIELD_W] !== '0) begin
                    $display("%0t: mismatch expected %0d %h %0d %0d, got %0d %h %0d %0d pad %h",
                             $time, want.status, want.key, want.num, want.st,
                             got.status, got.key, got.num, got.st,
                             o_m_tdata[DATA_W-1:FIELD_W]);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        plan_row_t   row;
        job_cmd_t    c;
        job_result_t none;
        seq_kind_t   kind;
        int          seq_len;
        int          rand_sent;
        int          seq_count;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        fail_count = 0;
        src_calm   = 0;
        next_job   = 1;
        for (int i = 0; i < SLOTS; i++) begin
            job_key[i] = '0;
            job_num[i] = '0;
            job_run[i] = '0;
        end
        none.status = STS_OK;
        none.key    = '0;
        none.num    = '0;
        none.st     = '0;

        // Opening walk: rejects, extremes, duplicates, clear
        opening_plan.push_back(plan(OP_FIND_FG, 0, 0, 0, 1, STS_NOTFOUND, 0, 0, 0));
        opening_plan.push_back(plan(OP_ADD, 0, 31, 1, 1, STS_INVALID, 0, 0, 0));
        opening_plan.push_back(plan(OP_REMOVE, 0, 5, 0, 1, STS_INVALID, 0, 0, 0));
        opening_plan.push_back(plan(OP_SET_KEY, 0, 1, 3, 1, STS_INVALID, 0, 0, 0));
        opening_plan.push_back(plan(OP_FIND_KEY, 0, 1, 0, 1, STS_INVALID, 0, 0, 0));
        opening_plan.push_back(plan(OP_SET_NUM, KEY_MAX, 0, 2, 1, STS_INVALID, 0, 0, 0));
        opening_plan.push_back(plan(OP_FIND_NUM, 7, 0, 0, 1, STS_INVALID, 0, 0, 0));
        opening_plan.push_back(plan(OP_ADD, KEY_MAX, 0, 3, 1, STS_OK, KEY_MAX, 1, 3));
        opening_plan.push_back(plan(OP_FIND_NUM, 0, 31, 0, 1, STS_NOTFOUND, 0, 0, 0));
        opening_plan.push_back(plan(OP_FIND_NUM, 0, 16, 0, 1, STS_NOTFOUND, 0, 0, 0));
        opening_plan.push_back(plan(OP_SET_NUM, 0, 1, RUN_FG, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_FIND_FG, 0, 0, 0, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_ADD, KEY_MAX, 0, 2, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_FIND_KEY, KEY_MAX, 0, 0, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_ADD, 1, 0, 0, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_SET_KEY, 1, 0, 3, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_REMOVE, KEY_MAX, 0, 0, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_FIND_NUM, 0, 2, 0, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_REMOVE, 2, 0, 0, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_CLEAR, KEY_MAX, 31, 3, 1, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_FIND_KEY, 1, 0, 0, 1, STS_NOTFOUND, 0, 0, 0));
        opening_plan.push_back(plan(OP_ADD, 22'h155555, 0, 1, 0, STS_OK, 0, 0, 0));
        opening_plan.push_back(plan(OP_ADD, 22'h2aaaaa, 0, 2, 0, STS_OK, 0, 0, 0));

        // hold reset at the start, release at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (opening_plan[i]) begin
            row = opening_plan[i];
            send_cmd(row.cmd, row.typed, row.res);
        end

        // Random part: well-formed runs with random content, some noise
        rand_sent = 0;
        seq_count = 0;
        while (rand_sent < RAND_ITEMS) begin
            if (seq_count == 0) begin
                // open with enough adds to hit the full table
                kind    = SEQ_FILL;
                seq_len = SLOTS + 1;
            end else begin
                case ($urandom_range(0, 15))
                    0, 1, 2, 3: kind = SEQ_FILL;
                    12, 13:     kind = SEQ_DRAIN;
                    14:         kind = SEQ_NOISE;
                    15:         kind = SEQ_CLEAR;
                    default:    kind = SEQ_WORK;
                endcase
                case (kind)
                    SEQ_FILL:  seq_len = $urandom_range(1, 18);
                    SEQ_DRAIN: seq_len = $urandom_range(1, 16);
                    SEQ_NOISE: seq_len = $urandom_range(1, 6);
                    SEQ_CLEAR: seq_len = 1;
                    default:   seq_len = $urandom_range(4, 24);
                endcase
            end
            seq_count++;
            repeat (seq_len) begin
                c = build_cmd(kind);
                send_cmd(c, 0, none);
                rand_sent++;
            end
        end

        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SLOTS * 3) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/jst_pkg.sv
src/jst_cell.sv
src/jst_ctrl.sv
src/job_slot_table_top.sv
verif/tb_top.sv
